@@ design/scd_pkg.sv @@
// Shared types, scancode constants and keymap tables for the set-1 key decoder.
// No dependencies; every other design file except scd_if imports this package.
`default_nettype none

package scd_pkg;

  localparam int KEYMAP_ENTRIES = 128;
  localparam int TAB_ROWS       = 64;   // table rows past this are all zero
  localparam int APB_ADDR_W     = 3;

  // Register word index, compared against paddr[2]
  localparam logic REG_ASCII_ONLY = 1'b0;

  // Raw scancodes
  localparam logic [7:0] PREFIX_EXT = 8'hE0;
  localparam logic [6:0] SC_ESC     = 7'h01;
  localparam logic [6:0] SC_BKSP    = 7'h0E;
  localparam logic [6:0] SC_TAB     = 7'h0F;
  localparam logic [6:0] SC_ENTER   = 7'h1C;
  localparam logic [6:0] SC_CTRL    = 7'h1D;
  localparam logic [6:0] SC_LSHIFT  = 7'h2A;
  localparam logic [6:0] SC_RSHIFT  = 7'h36;
  localparam logic [6:0] SC_ALT     = 7'h38;
  localparam logic [6:0] SC_CAPS    = 7'h3A;
  localparam logic [6:0] SC_F1      = 7'h3B;
  localparam logic [6:0] SC_F10     = 7'h44;
  localparam logic [6:0] SC_F11     = 7'h57;
  localparam logic [6:0] SC_F12     = 7'h58;
  localparam logic [6:0] SC_META_L  = 7'h5B;
  localparam logic [6:0] SC_META_R  = 7'h5C;
  localparam logic [6:0] SC_UP      = 7'h48;
  localparam logic [6:0] SC_DOWN    = 7'h50;
  localparam logic [6:0] SC_LEFT    = 7'h4B;
  localparam logic [6:0] SC_RIGHT   = 7'h4D;
  localparam logic [6:0] SC_HOME    = 7'h47;
  localparam logic [6:0] SC_END     = 7'h4F;
  localparam logic [6:0] SC_PGUP    = 7'h49;
  localparam logic [6:0] SC_PGDN    = 7'h51;
  localparam logic [6:0] SC_INS     = 7'h52;
  localparam logic [6:0] SC_DEL     = 7'h53;

  // Key codes
  localparam logic [8:0] KC_NONE  = 9'h000;
  localparam logic [8:0] KC_ESC   = 9'h100;
  localparam logic [8:0] KC_BKSP  = 9'h101;
  localparam logic [8:0] KC_TAB   = 9'h102;
  localparam logic [8:0] KC_ENTER = 9'h103;
  localparam logic [8:0] KC_UP    = 9'h104;
  localparam logic [8:0] KC_DOWN  = 9'h105;
  localparam logic [8:0] KC_LEFT  = 9'h106;
  localparam logic [8:0] KC_RIGHT = 9'h107;
  localparam logic [8:0] KC_HOME  = 9'h108;
  localparam logic [8:0] KC_END   = 9'h109;
  localparam logic [8:0] KC_PGUP  = 9'h10A;
  localparam logic [8:0] KC_PGDN  = 9'h10B;
  localparam logic [8:0] KC_INS   = 9'h10C;
  localparam logic [8:0] KC_DEL   = 9'h10D;
  localparam logic [8:0] KC_F1    = 9'h10E;
  localparam logic [8:0] KC_F11   = 9'h118;
  localparam logic [8:0] KC_F12   = 9'h119;

  localparam logic [6:0] LOWER_TAB [TAB_ROWS] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [6:0] UPPER_TAB [TAB_ROWS] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  typedef struct packed {
    logic ext;
    logic shift;
    logic caps;
    logic ctrl;
    logic alt;
    logic meta;
  } scd_state_t;

  typedef struct packed {
    logic       emit;
    logic [8:0] key_code;
    logic       released;
    logic [4:0] modifiers;
  } scd_result_t;

  function automatic logic [6:0] lower_char(input logic [6:0] c);
    return c[6] ? 7'h00 : LOWER_TAB[c[5:0]];
  endfunction

  function automatic logic [6:0] upper_char(input logic [6:0] c);
    return c[6] ? 7'h00 : UPPER_TAB[c[5:0]];
  endfunction

  function automatic logic [8:0] nav_key(input logic [6:0] c);
    logic [8:0] k;
    unique case (c)
      SC_UP:    k = KC_UP;
      SC_DOWN:  k = KC_DOWN;
      SC_LEFT:  k = KC_LEFT;
      SC_RIGHT: k = KC_RIGHT;
      SC_HOME:  k = KC_HOME;
      SC_END:   k = KC_END;
      SC_PGUP:  k = KC_PGUP;
      SC_PGDN:  k = KC_PGDN;
      SC_INS:   k = KC_INS;
      SC_DEL:   k = KC_DEL;
      default:  k = KC_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

@@ design/scd_if.sv @@
// Valid/ready channel interfaces for scan bytes in and key events out.
// No dependencies.
`default_nettype none

interface scd_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink (input valid, input scan_byte, output ready);
endinterface

interface scd_key_if;
  logic       valid;
  logic       ready;
  logic [8:0] key_code;
  logic       released;
  logic [4:0] modifiers;

  modport source (output valid, output key_code, output released, output modifiers,
                  input ready);
  modport sink (input valid, input key_code, input released, input modifiers,
                output ready);
endinterface

`default_nettype wire

@@ design/scancode_set1_key_decoder.sv @@
// Set-1 scancode key decoder, top level.
// Datapath: input register, one decode pass, result register.
// Throughput: one scan byte per cycle unless key_out stalls the result register.
// Reset clears the prefix flag, all modifier bits, the mode bit and both valid stages.
// Depends on scd_pkg, scd_if, scd_cfg and scd_decode.
`default_nettype none

module scancode_set1_key_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  scd_scan_if.sink                           scan_in,
  scd_key_if.source                          key_out,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [scd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import scd_pkg::*;

  logic        ascii_only;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  scd_state_t  state;
  scd_state_t  state_next;
  scd_result_t result;
  logic        out_valid;
  logic [8:0]  out_code;
  logic        out_rel;
  logic [4:0]  out_mods;
  logic        advance;

  scd_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .ascii_only (ascii_only)
  );

  scd_decode u_decode (
    .scan_byte  (s1_byte),
    .ascii_only (ascii_only),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  // result register frees up when empty or being taken
  assign advance       = !out_valid || key_out.ready;
  assign scan_in.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (scan_in.ready) s1_valid <= scan_in.valid;
      if (s1_valid && advance) state <= state_next;
      if (advance) out_valid <= s1_valid && result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_in.valid && scan_in.ready) s1_byte <= scan_in.scan_byte;
    if (s1_valid && advance) begin
      out_code <= result.key_code;
      out_rel  <= result.released;
      out_mods <= result.modifiers;
    end
  end

  assign key_out.valid     = out_valid;
  assign key_out.key_code  = out_code;
  assign key_out.released  = out_rel;
  assign key_out.modifiers = out_mods;

endmodule

`default_nettype wire

@@ design/scd_cfg.sv @@
// APB register block holding the ascii_only mode bit.
// Depends on scd_pkg.
`default_nettype none

module scd_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [scd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output logic                               ascii_only
);
  import scd_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_ASCII_ONLY);

  always_ff @(posedge clk) begin
    if (rst) begin
      ascii_only <= 1'b0;
    end else if (wr_en) begin
      ascii_only <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ASCII_ONLY) begin
      prdata = {31'b0, ascii_only};
    end
  end

endmodule

`default_nettype wire

@@ design/scd_decode.sv @@
// Single-pass decode of one scan byte: next modifier/prefix state and event.
// Depends on scd_pkg for tables, scancodes and key codes.
`default_nettype none

module scd_decode (
  input  wire logic [7:0]          scan_byte,
  input  wire logic                ascii_only,
  input  wire scd_pkg::scd_state_t state,
  output scd_pkg::scd_state_t      state_next,
  output scd_pkg::scd_result_t     result
);
  import scd_pkg::*;

  logic       rel;
  logic [6:0] c;
  logic [6:0] lo;
  logic [6:0] hi;
  logic       letter;
  logic       up;
  logic [6:0] chr;
  logic [8:0] nav;
  logic [8:0] fk;
  logic       is_fk;
  logic       emit;
  logic [8:0] code;

  assign rel    = scan_byte[7];
  assign c      = scan_byte[6:0];
  assign lo     = lower_char(c);
  assign hi     = upper_char(c);
  assign letter = (lo >= 7'h61) && (lo <= 7'h7A);
  assign up     = letter ? (state.shift ^ state.caps) : state.shift;
  assign chr    = up ? hi : lo;
  assign nav    = nav_key(c);

  always_comb begin
    fk    = KC_NONE;
    is_fk = 1'b0;
    if (c >= SC_F1 && c <= SC_F10) begin
      fk    = KC_F1 + ({2'b00, c} - {2'b00, SC_F1});
      is_fk = 1'b1;
    end else if (c == SC_F11) begin
      fk    = KC_F11;
      is_fk = 1'b1;
    end else if (c == SC_F12) begin
      fk    = KC_F12;
      is_fk = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    code       = KC_NONE;
    if (scan_byte == PREFIX_EXT) begin
      state_next.ext = 1'b1;
    end else begin
      state_next.ext = 1'b0;
      if (ascii_only) begin
        // only shift and caps are tracked; extended bytes drop out
        if (!state.ext) begin
          if (c == SC_LSHIFT || c == SC_RSHIFT) begin
            state_next.shift = !rel;
          end else if (c == SC_CAPS) begin
            if (!rel) state_next.caps = !state.caps;
          end else if (!rel && lo != 7'h00) begin
            emit = 1'b1;
            code = {2'b00, chr};
          end
        end
      end else if (state.ext) begin
        if (c == SC_CTRL) begin
          state_next.ctrl = !rel;
          emit            = 1'b1;
        end else if (c == SC_ALT) begin
          state_next.alt = !rel;
          emit           = 1'b1;
        end else if (c == SC_META_L || c == SC_META_R) begin
          state_next.meta = !rel;
          emit            = 1'b1;
        end else if (nav != KC_NONE) begin
          emit = 1'b1;
          code = nav;
        end
      end else begin
        if (c == SC_LSHIFT || c == SC_RSHIFT) begin
          state_next.shift = !rel;
          emit             = 1'b1;
        end else if (c == SC_CTRL) begin
          state_next.ctrl = !rel;
          emit            = 1'b1;
        end else if (c == SC_ALT) begin
          state_next.alt = !rel;
          emit           = 1'b1;
        end else if (c == SC_CAPS) begin
          if (!rel) state_next.caps = !state.caps;
          emit = 1'b1;
        end else if (c == SC_ESC) begin
          emit = 1'b1;
          code = KC_ESC;
        end else if (c == SC_BKSP) begin
          emit = 1'b1;
          code = KC_BKSP;
        end else if (c == SC_TAB) begin
          emit = 1'b1;
          code = KC_TAB;
        end else if (c == SC_ENTER) begin
          emit = 1'b1;
          code = KC_ENTER;
        end else if (is_fk) begin
          emit = 1'b1;
          code = fk;
        end else if (lo != 7'h00) begin
          emit = 1'b1;
          code = {2'b00, chr};
        end
      end
    end
  end

  always_comb begin
    result.emit      = emit;
    result.key_code  = code;
    result.released  = rel && !ascii_only;
    result.modifiers = {state_next.caps, state_next.meta, state_next.alt,
                        state_next.ctrl, state_next.shift};
  end

endmodule

`default_nettype wire
